@@ design/instruction_format_predecoder_assert.svh @@
// Assertion macros for the instruction format predecoder.
`ifndef INSTRUCTION_FORMAT_PREDECODER_ASSERT_SVH
`define INSTRUCTION_FORMAT_PREDECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define IFP_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label failed");
`define IFP_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label failed");
`else
`define IFP_ASSERT_IMPL(label, clk, rst, prop)
`define IFP_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ design/ifp_pkg.sv @@
// Package with the opcode table, format classes and helpers of the predecoder.
`default_nettype none
package ifp_pkg;

  localparam int unsigned OpcCount = 183;
  localparam logic [15:0] SbDirBit = 16'h0100;

  typedef enum logic [3:0] {
    FMT_MASK_REG = 4'd0, FMT_REG_REG = 4'd1, FMT_REG = 4'd2, FMT_MASK_MEM = 4'd3,
    FMT_REG_MEM = 4'd4, FMT_MEM = 4'd5, FMT_FLT_FLT = 4'd6, FMT_FLT_MEM = 4'd7,
    FMT_SHORT_IMM = 4'd8, FMT_SHORT_BR = 4'd9, FMT_EXT_SHORT_BR = 4'd10
  } fmt_t;

  typedef struct packed {
    logic [15:0] pattern;
    fmt_t        fmt;
  } opc_entry_t;

  function automatic logic [15:0] class_mask(input fmt_t f);
    logic [15:0] m;
    unique case (f)
      FMT_REG, FMT_MEM:  m = 16'hFFF0;
      FMT_SHORT_BR:      m = 16'hFE00;
      FMT_EXT_SHORT_BR:  m = 16'hFEF0;
      default:           m = 16'hFF00;
    endcase
    return m;
  endfunction

  function automatic logic is_mem_fmt(input fmt_t f);
    return (f == FMT_MASK_MEM) || (f == FMT_REG_MEM) || (f == FMT_MEM) ||
           (f == FMT_FLT_MEM);
  endfunction

  function automatic logic is_branch_fmt(input fmt_t f);
    return (f == FMT_SHORT_BR) || (f == FMT_EXT_SHORT_BR);
  endfunction

  function automatic opc_entry_t E(input logic [15:0] p, input fmt_t f);
    opc_entry_t e;
    e.pattern = p;
    e.fmt = f;
    return e;
  endfunction

  function automatic opc_entry_t opc_entry(input logic [7:0] i);
    opc_entry_t e;
    unique case (i)
      8'd0: e = E(16'h0330, FMT_REG);    8'd1: e = E(16'h0230, FMT_REG);
      8'd2: e = E(16'h0330, FMT_REG);    8'd3: e = E(16'h0230, FMT_REG);
      8'd4: e = E(16'h0220, FMT_REG);    8'd5: e = E(16'h0320, FMT_REG);
      8'd6: e = E(16'h0280, FMT_REG);    8'd7: e = E(16'h0380, FMT_REG);
      8'd8: e = E(16'h0210, FMT_REG);    8'd9: e = E(16'h0310, FMT_REG);
      8'd10: e = E(16'h0240, FMT_REG);   8'd11: e = E(16'h0340, FMT_REG);
      8'd12: e = E(16'h0280, FMT_REG);   8'd13: e = E(16'h0380, FMT_REG);
      8'd14: e = E(16'h0300, FMT_REG);
      8'd15: e = E(16'h2230, FMT_EXT_SHORT_BR); 8'd16: e = E(16'h2030, FMT_EXT_SHORT_BR);
      8'd17: e = E(16'h2230, FMT_EXT_SHORT_BR); 8'd18: e = E(16'h2030, FMT_EXT_SHORT_BR);
      8'd19: e = E(16'h2020, FMT_EXT_SHORT_BR); 8'd20: e = E(16'h2220, FMT_EXT_SHORT_BR);
      8'd21: e = E(16'h2080, FMT_EXT_SHORT_BR); 8'd22: e = E(16'h2280, FMT_EXT_SHORT_BR);
      8'd23: e = E(16'h2010, FMT_EXT_SHORT_BR); 8'd24: e = E(16'h2210, FMT_EXT_SHORT_BR);
      8'd25: e = E(16'h2040, FMT_EXT_SHORT_BR); 8'd26: e = E(16'h2240, FMT_EXT_SHORT_BR);
      8'd27: e = E(16'h2080, FMT_EXT_SHORT_BR); 8'd28: e = E(16'h2280, FMT_EXT_SHORT_BR);
      8'd29: e = E(16'h2200, FMT_EXT_SHORT_BR);
      8'd30: e = E(16'h4330, FMT_MEM);   8'd31: e = E(16'h4230, FMT_MEM);
      8'd32: e = E(16'h4330, FMT_MEM);   8'd33: e = E(16'h4230, FMT_MEM);
      8'd34: e = E(16'h4220, FMT_MEM);   8'd35: e = E(16'h4320, FMT_MEM);
      8'd36: e = E(16'h4280, FMT_MEM);   8'd37: e = E(16'h4380, FMT_MEM);
      8'd38: e = E(16'h4210, FMT_MEM);   8'd39: e = E(16'h4310, FMT_MEM);
      8'd40: e = E(16'h4240, FMT_MEM);   8'd41: e = E(16'h4340, FMT_MEM);
      8'd42: e = E(16'h4280, FMT_MEM);   8'd43: e = E(16'h4380, FMT_MEM);
      8'd44: e = E(16'h4300, FMT_MEM);
      8'd45: e = E(16'h0100, FMT_REG_REG);  8'd46: e = E(16'h0200, FMT_MASK_REG);
      8'd47: e = E(16'h0300, FMT_MASK_REG);
      8'd48: e = E(16'h0400, FMT_REG_REG);  8'd49: e = E(16'h0500, FMT_REG_REG);
      8'd50: e = E(16'h0600, FMT_REG_REG);  8'd51: e = E(16'h0700, FMT_REG_REG);
      8'd52: e = E(16'h0800, FMT_REG_REG);  8'd53: e = E(16'h0900, FMT_REG_REG);
      8'd54: e = E(16'h0A00, FMT_REG_REG);  8'd55: e = E(16'h0B00, FMT_REG_REG);
      8'd56: e = E(16'h0C00, FMT_REG_REG);  8'd57: e = E(16'h0D00, FMT_REG_REG);
      8'd58: e = E(16'h0E00, FMT_REG_REG);  8'd59: e = E(16'h0F00, FMT_REG_REG);
      8'd60: e = E(16'h1300, FMT_REG_REG);
      8'd61: e = E(16'h2000, FMT_SHORT_BR); 8'd62: e = E(16'h2100, FMT_SHORT_BR);
      8'd63: e = E(16'h2200, FMT_SHORT_BR); 8'd64: e = E(16'h2300, FMT_SHORT_BR);
      8'd65: e = E(16'h2400, FMT_SHORT_IMM); 8'd66: e = E(16'h2500, FMT_SHORT_IMM);
      8'd67: e = E(16'h2600, FMT_SHORT_IMM); 8'd68: e = E(16'h2700, FMT_SHORT_IMM);
      8'd69: e = E(16'h2800, FMT_FLT_FLT);  8'd70: e = E(16'h2900, FMT_FLT_FLT);
      8'd71: e = E(16'h2A00, FMT_FLT_FLT);  8'd72: e = E(16'h2B00, FMT_FLT_FLT);
      8'd73: e = E(16'h2C00, FMT_FLT_FLT);  8'd74: e = E(16'h2D00, FMT_FLT_FLT);
      8'd75: e = E(16'h2E00, FMT_REG_REG);  8'd76: e = E(16'h2F00, FMT_REG_REG);
      8'd77: e = E(16'h3300, FMT_REG);
      8'd78: e = E(16'h3800, FMT_FLT_FLT);  8'd79: e = E(16'h3900, FMT_FLT_FLT);
      8'd80: e = E(16'h3A00, FMT_FLT_FLT);  8'd81: e = E(16'h3B00, FMT_FLT_FLT);
      8'd82: e = E(16'h3C00, FMT_FLT_FLT);  8'd83: e = E(16'h3D00, FMT_FLT_FLT);
      8'd84: e = E(16'h3E00, FMT_REG_REG);  8'd85: e = E(16'h3F00, FMT_REG_REG);
      8'd86: e = E(16'h4000, FMT_REG_MEM);  8'd87: e = E(16'h4100, FMT_REG_MEM);
      8'd88: e = E(16'h4200, FMT_MASK_MEM); 8'd89: e = E(16'h4300, FMT_MASK_MEM);
      8'd90: e = E(16'h4400, FMT_REG_MEM);  8'd91: e = E(16'h4500, FMT_REG_MEM);
      8'd92: e = E(16'h4600, FMT_REG_MEM);  8'd93: e = E(16'h4700, FMT_REG_MEM);
      8'd94: e = E(16'h4800, FMT_REG_MEM);  8'd95: e = E(16'h4900, FMT_REG_MEM);
      8'd96: e = E(16'h4A00, FMT_REG_MEM);  8'd97: e = E(16'h4B00, FMT_REG_MEM);
      8'd98: e = E(16'h4C00, FMT_REG_MEM);  8'd99: e = E(16'h4D00, FMT_REG_MEM);
      8'd100: e = E(16'h4E00, FMT_REG_MEM); 8'd101: e = E(16'h4F00, FMT_REG_MEM);
      8'd102: e = E(16'h5300, FMT_REG_MEM);
      8'd103: e = E(16'h6000, FMT_REG_MEM); 8'd104: e = E(16'h6100, FMT_REG_MEM);
      8'd105: e = E(16'h6400, FMT_REG_MEM); 8'd106: e = E(16'h6500, FMT_REG_MEM);
      8'd107: e = E(16'h6600, FMT_REG_MEM); 8'd108: e = E(16'h6700, FMT_REG_MEM);
      8'd109: e = E(16'h6800, FMT_FLT_MEM); 8'd110: e = E(16'h6900, FMT_FLT_MEM);
      8'd111: e = E(16'h6A00, FMT_FLT_MEM); 8'd112: e = E(16'h6B00, FMT_FLT_MEM);
      8'd113: e = E(16'h6C00, FMT_FLT_MEM); 8'd114: e = E(16'h6D00, FMT_FLT_MEM);
      8'd115: e = E(16'h7000, FMT_FLT_MEM); 8'd116: e = E(16'h7100, FMT_FLT_MEM);
      8'd117: e = E(16'h7200, FMT_FLT_MEM); 8'd118: e = E(16'h7300, FMT_MEM);
      8'd119: e = E(16'h7800, FMT_FLT_MEM); 8'd120: e = E(16'h7900, FMT_FLT_MEM);
      8'd121: e = E(16'h7A00, FMT_FLT_MEM); 8'd122: e = E(16'h7B00, FMT_FLT_MEM);
      8'd123: e = E(16'h7C00, FMT_FLT_MEM); 8'd124: e = E(16'h7D00, FMT_FLT_MEM);
      8'd125: e = E(16'h7E00, FMT_FLT_MEM); 8'd126: e = E(16'h7F00, FMT_FLT_MEM);
      8'd127: e = E(16'h9000, FMT_SHORT_IMM); 8'd128: e = E(16'h9100, FMT_SHORT_IMM);
      8'd129: e = E(16'h9200, FMT_REG_REG); 8'd130: e = E(16'h9300, FMT_REG_REG);
      8'd131: e = E(16'h9400, FMT_REG_REG); 8'd132: e = E(16'h9500, FMT_REG_REG);
      8'd133: e = E(16'h9600, FMT_REG_REG); 8'd134: e = E(16'h9700, FMT_REG_REG);
      8'd135: e = E(16'h9800, FMT_REG_REG); 8'd136: e = E(16'h9900, FMT_REG_REG);
      8'd137: e = E(16'h9A00, FMT_REG_REG); 8'd138: e = E(16'h9B00, FMT_REG_REG);
      8'd139: e = E(16'h9C00, FMT_REG_REG); 8'd140: e = E(16'h9D00, FMT_REG_REG);
      8'd141: e = E(16'h9E00, FMT_REG_REG); 8'd142: e = E(16'h9F00, FMT_REG_REG);
      8'd143: e = E(16'hC000, FMT_REG_MEM); 8'd144: e = E(16'hC100, FMT_REG_MEM);
      8'd145: e = E(16'hC200, FMT_MEM);     8'd146: e = E(16'hC300, FMT_REG_MEM);
      8'd147: e = E(16'hC400, FMT_REG_MEM); 8'd148: e = E(16'hC500, FMT_REG_MEM);
      8'd149: e = E(16'hC600, FMT_REG_MEM); 8'd150: e = E(16'hC700, FMT_REG_MEM);
      8'd151: e = E(16'hC800, FMT_REG_MEM); 8'd152: e = E(16'hC900, FMT_REG_MEM);
      8'd153: e = E(16'hCA00, FMT_REG_MEM); 8'd154: e = E(16'hCB00, FMT_REG_MEM);
      8'd155: e = E(16'hCC00, FMT_REG_MEM); 8'd156: e = E(16'hCD00, FMT_REG_MEM);
      8'd157: e = E(16'hCE00, FMT_REG_MEM); 8'd158: e = E(16'hCF00, FMT_REG_MEM);
      8'd159: e = E(16'hD000, FMT_REG_MEM); 8'd160: e = E(16'hD100, FMT_REG_MEM);
      8'd161: e = E(16'hD200, FMT_REG_MEM); 8'd162: e = E(16'hD300, FMT_REG_MEM);
      8'd163: e = E(16'hD400, FMT_REG_MEM); 8'd164: e = E(16'hD500, FMT_MEM);
      8'd165: e = E(16'hD600, FMT_REG_MEM); 8'd166: e = E(16'hD700, FMT_REG_MEM);
      8'd167: e = E(16'hD800, FMT_REG_MEM); 8'd168: e = E(16'hD900, FMT_REG_MEM);
      8'd169: e = E(16'hDA00, FMT_REG_MEM); 8'd170: e = E(16'hDB00, FMT_REG_MEM);
      8'd171: e = E(16'hDC00, FMT_REG_MEM); 8'd172: e = E(16'hDD00, FMT_REG_MEM);
      8'd173: e = E(16'hDE00, FMT_REG_MEM); 8'd174: e = E(16'hDF00, FMT_REG_MEM);
      8'd175: e = E(16'hE100, FMT_REG_MEM); 8'd176: e = E(16'hE200, FMT_REG_MEM);
      8'd177: e = E(16'hEA00, FMT_REG_MEM); 8'd178: e = E(16'hEB00, FMT_REG_MEM);
      8'd179: e = E(16'hEC00, FMT_REG_MEM); 8'd180: e = E(16'hED00, FMT_REG_MEM);
      8'd181: e = E(16'hEE00, FMT_REG_MEM); 8'd182: e = E(16'hEF00, FMT_REG_MEM);
      default: e = E(16'h0000, FMT_MASK_REG);
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

@@ design/ifp_if.sv @@
// Valid/ready channel interfaces for the predecoder's request and result.
`default_nettype none
interface ifp_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_halfword;
  logic [15:0] second_halfword;
  logic [15:0] program_counter;
  modport source (output valid, first_halfword, second_halfword, program_counter,
                  input ready);
  modport sink (input valid, first_halfword, second_halfword, program_counter,
                output ready);
endinterface

interface ifp_rsp_if;
  logic              valid;
  logic              ready;
  logic              matched;
  logic [7:0]        opcode_index;
  logic [3:0]        format_class;
  logic [3:0]        field_r1;
  logic [3:0]        field_r2;
  logic [15:0]       address_word;
  logic [2:0]        length_bytes;
  logic [15:0]       short_target;
  logic signed [5:0] short_offset;
  modport source (output valid, matched, opcode_index, format_class, field_r1, field_r2,
                  address_word, length_bytes, short_target, short_offset,
                  input ready);
  modport sink (input valid, matched, opcode_index, format_class, field_r1, field_r2,
                address_word, length_bytes, short_target, short_offset,
                output ready);
endinterface
`default_nettype wire

@@ design/instruction_format_predecoder.sv @@
// Top level of the instruction format predecoder.
// The block takes one request per cycle on req while req.ready is high: the
// instruction halfword, the halfword that follows it and the program counter.
// It returns one result per request on rsp, in order. A request is taken at a
// rising edge where valid and ready are both high.
// An accepted request is held in an input register. In the next cycle the 183
// table entries are compared in parallel against the halfword under each
// entry's format mask, and a priority encoder picks the first hit. Result
// fields are formed from that hit and loaded into the result register.
// Throughput is one request per cycle while the receiver keeps rsp.ready high;
// the input register and the result register together form a two-deep pipe
// that advances whenever the result register is empty or being drained.
// When the receiver holds rsp.ready low the pipe fills and req.ready falls
// once both stages hold an item, so no request is lost or repeated.
// A synchronous reset on rst empties both stages; nothing else is reset.
`default_nettype none
`include "instruction_format_predecoder_assert.svh"
module instruction_format_predecoder
  import ifp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  ifp_req_if.sink   req,
  ifp_rsp_if.source rsp
);

  // Input stage.
  logic        in_valid;
  logic [15:0] in_first;
  logic [15:0] in_second;
  logic [15:0] in_pc;
  logic        adv;

  // The result stage takes a new item when it is empty or being drained.
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_first  <= req.first_halfword;
      in_second <= req.second_halfword;
      in_pc     <= req.program_counter;
    end
  end

  // Parallel table compare.
  logic [OpcCount-1:0] hit;
  always_comb begin
    opc_entry_t e;
    for (int i = 0; i < OpcCount; i++) begin
      e = opc_entry(8'(i));
      hit[i] = (e.pattern == (in_first & class_mask(e.fmt)));
    end
  end

  // First hit wins.
  logic       any_hit;
  logic [7:0] idx;
  always_comb begin
    any_hit = 1'b0;
    idx     = 8'd0;
    for (int i = OpcCount - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        idx     = 8'(i);
      end
    end
  end

  logic              m_next;
  logic [7:0]        idx_next;
  logic [3:0]        fmt_next;
  logic [3:0]        r1_next;
  logic [3:0]        r2_next;
  logic [15:0]       addr_next;
  logic [2:0]        len_next;
  logic [15:0]       tgt_next;
  logic [5:0]        off_next;
  always_comb begin
    fmt_t       f;
    logic [4:0] d;
    f         = opc_entry(idx).fmt;
    d         = {in_first[3:0], 1'b0};
    m_next    = any_hit;
    idx_next  = any_hit ? idx : 8'd0;
    fmt_next  = any_hit ? 4'(f) : 4'd0;
    r1_next   = any_hit ? in_first[7:4] : 4'd0;
    r2_next   = any_hit ? in_first[3:0] : 4'd0;
    addr_next = 16'd0;
    len_next  = 3'd2;
    tgt_next  = 16'd0;
    off_next  = 6'd0;
    if (any_hit && is_mem_fmt(f)) begin
      addr_next = in_second;
      len_next  = 3'd4;
    end
    if (any_hit && is_branch_fmt(f)) begin
      if ((in_first & SbDirBit) != 16'd0) begin
        tgt_next = in_pc + 16'(d);
        off_next = 6'(d);
      end else begin
        tgt_next = in_pc - 16'(d);
        off_next = 6'd0 - 6'(d);
      end
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      rsp.matched      <= m_next;
      rsp.opcode_index <= idx_next;
      rsp.format_class <= fmt_next;
      rsp.field_r1     <= r1_next;
      rsp.field_r2     <= r2_next;
      rsp.address_word <= addr_next;
      rsp.length_bytes <= len_next;
      rsp.short_target <= tgt_next;
      rsp.short_offset <= off_next;
    end
  end

  `IFP_ASSERT_IMPL(a_len_mem, clk, rst, rsp.valid |-> ((rsp.length_bytes == 3'd4) || (rsp.address_word == 16'd0)))
  `IFP_ASSERT_IMPL(a_nomatch_zero, clk, rst, (rsp.valid && !rsp.matched) |-> (rsp.opcode_index == 8'd0 && rsp.length_bytes == 3'd2))
  `IFP_ASSERT_IMPL(a_stall_hold, clk, rst, (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.opcode_index)))
  `IFP_ASSERT_RST(a_reset_empty, clk, $past(rst) |-> (!rsp.valid && !in_valid))

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the instruction format predecoder.
`default_nettype none
module testbench;
  import ifp_pkg::*;

  // Expected decode of one request, at the widths of the result channel.
  typedef struct packed {
    logic              matched;
    logic [7:0]        opcode_index;
    logic [3:0]        format_class;
    logic [3:0]        field_r1;
    logic [3:0]        field_r2;
    logic [15:0]       address_word;
    logic [2:0]        length_bytes;
    logic [15:0]       short_target;
    logic signed [5:0] short_offset;
  } decode_t;

  // One pending instruction request as the driver sends it.
  typedef struct packed {
    logic [15:0] first_halfword;
    logic [15:0] second_halfword;
    logic [15:0] program_counter;
  } fetch_t;

  localparam int TotalRandom = 1100;
  localparam int CycleLimit = 400000;
  // Idle bursts stop for the final stretch of the random part.
  localparam int QuietTail = 150;

  logic clk;
  logic rst;
  ifp_req_if req ();
  ifp_rsp_if rsp ();

  instruction_format_predecoder dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  fetch_t  fetch_queue[$];
  decode_t decode_queue[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      send_gap = 0;
  int      drain_stall = 0;
  bit      stimulus_done = 0;

  // Independent table lookup: first match wins, mask chosen by the format.
  // The table itself is shared with the package since it is a fixed constant.
  function automatic decode_t predict_decode(input fetch_t f);
    decode_t     d;
    opc_entry_t  e;
    logic [15:0] m;
    logic [15:0] dist2;
    d = '0;
    d.length_bytes = 3'd2;
    for (int i = 0; i < OpcCount; i++) begin
      e = opc_entry(i[7:0]);
      case (e.fmt)
        FMT_REG, FMT_MEM: m = 16'hFFF0;
        FMT_SHORT_BR: m = 16'hFE00;
        FMT_EXT_SHORT_BR: m = 16'hFEF0;
        default: m = 16'hFF00;
      endcase
      if (e.pattern == (f.first_halfword & m)) begin
        d.matched = 1'b1;
        d.opcode_index = i[7:0];
        d.format_class = e.fmt;
        d.field_r1 = f.first_halfword[7:4];
        d.field_r2 = f.first_halfword[3:0];
        if (e.fmt inside {FMT_MASK_MEM, FMT_REG_MEM, FMT_MEM, FMT_FLT_MEM}) begin
          d.address_word = f.second_halfword;
          d.length_bytes = 3'd4;
        end
        if (e.fmt == FMT_SHORT_BR || e.fmt == FMT_EXT_SHORT_BR) begin
          dist2 = {11'd0, f.first_halfword[3:0], 1'b0};
          // Bit 8 picks a forward branch; otherwise the branch goes back.
          if (f.first_halfword[8]) begin
            d.short_target = f.program_counter + dist2;
            d.short_offset = dist2[5:0];
          end else begin
            d.short_target = f.program_counter - dist2;
            d.short_offset = -dist2[5:0];
          end
        end
        break;
      end
    end
    return d;
  endfunction

  function automatic fetch_t make_fetch(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] c);
    fetch_t f;
    f.first_halfword = a;
    f.second_halfword = b;
    f.program_counter = c;
    return f;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stimulus: directed corner cases first, then mostly table hits with random
  // operand bits, plus fully random halfwords that are often invalid opcodes.
  initial begin
    opc_entry_t e;
    logic [15:0] hw;
    rst = 1'b1;
    // All-zero and all-one fields, and pc wrap in both branch directions.
    fetch_queue.push_back(make_fetch(16'h0000, 16'h0000, 16'h0000));
    fetch_queue.push_back(make_fetch(16'hFFFF, 16'hFFFF, 16'hFFFF));
    fetch_queue.push_back(make_fetch(16'h210F, 16'hFFFF, 16'hFFF8));
    fetch_queue.push_back(make_fetch(16'h200F, 16'h0000, 16'h0004));
    fetch_queue.push_back(make_fetch(16'h223F, 16'h1234, 16'h0000));
    fetch_queue.push_back(make_fetch(16'h203F, 16'h1234, 16'hFFFF));
    fetch_queue.push_back(make_fetch(16'h2100, 16'h5555, 16'h8000));
    // Shadowed register entries, masked-off low bits of memory formats.
    fetch_queue.push_back(make_fetch(16'h0335, 16'hAAAA, 16'h0100));
    fetch_queue.push_back(make_fetch(16'h433F, 16'hBEEF, 16'h0200));
    fetch_queue.push_back(make_fetch(16'h0100, 16'h0001, 16'h0000));
    fetch_queue.push_back(make_fetch(16'h4200, 16'h8000, 16'h0000));
    fetch_queue.push_back(make_fetch(16'h2400, 16'h0000, 16'h0000));
    fetch_queue.push_back(make_fetch(16'h28FF, 16'h0000, 16'h0000));
    fetch_queue.push_back(make_fetch(16'h7FFF, 16'hFFFF, 16'h0000));
    fetch_queue.push_back(make_fetch(16'hEF5A, 16'h7FFF, 16'h0000));
    fetch_queue.push_back(make_fetch(16'h1000, 16'h0000, 16'h0000));
    fetch_queue.push_back(make_fetch(16'h0350, 16'h0000, 16'h0000));
    for (int n = 0; n < TotalRandom; n++) begin
      if ($urandom_range(0, 3) != 0) begin
        e = opc_entry(8'($urandom_range(0, OpcCount - 1)));
        hw = e.pattern | ~class_mask(e.fmt) & 16'($urandom);
      end else begin
        hw = 16'($urandom);
      end
      fetch_queue.push_back(make_fetch(hw, 16'($urandom), 16'($urandom)));
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: one request held on req until it is taken.
  initial begin
    req.valid = 1'b0;
    req.first_halfword = '0;
    req.second_halfword = '0;
    req.program_counter = '0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk) begin
    fetch_t f;
    logic   take;
    take = req.valid && req.ready;
    if (take) begin
      decode_queue.push_back(predict_decode({req.first_halfword, req.second_halfword,
                                             req.program_counter}));
    end
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || take) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req.valid <= 1'b0;
      end else if (fetch_queue.size() > 0) begin
        if (fetch_queue.size() > QuietTail && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(1, 17) - 1;
          req.valid <= 1'b0;
        end else begin
          f = fetch_queue.pop_front();
          req.valid <= 1'b1;
          req.first_halfword <= f.first_halfword;
          req.second_halfword <= f.second_halfword;
          req.program_counter <= f.program_counter;
        end
      end else begin
        req.valid <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // Monitor: check each taken result against the oldest expected decode,
  // and stall the receiver in random bursts.
  always @(posedge clk) begin
    decode_t d;
    if (rsp.valid && rsp.ready && !rst) begin
      if (decode_queue.size() == 0) begin
        $error("result with no request pending");
        error_count++;
      end else begin
        d = decode_queue.pop_front();
        if (rsp.matched !== d.matched) begin
          $error("matched: expected %0d got %0d", d.matched, rsp.matched);
          error_count++;
        end
        if (rsp.opcode_index !== d.opcode_index) begin
          $error("opcode_index: expected %0d got %0d", d.opcode_index, rsp.opcode_index);
          error_count++;
        end
        if (rsp.format_class !== d.format_class) begin
          $error("format_class: expected %0d got %0d", d.format_class, rsp.format_class);
          error_count++;
        end
        if (rsp.field_r1 !== d.field_r1) begin
          $error("field_r1: expected %0d got %0d", d.field_r1, rsp.field_r1);
          error_count++;
        end
        if (rsp.field_r2 !== d.field_r2) begin
          $error("field_r2: expected %0d got %0d", d.field_r2, rsp.field_r2);
          error_count++;
        end
        if (rsp.address_word !== d.address_word) begin
          $error("address_word: expected %h got %h", d.address_word, rsp.address_word);
          error_count++;
        end
        if (rsp.length_bytes !== d.length_bytes) begin
          $error("length_bytes: expected %0d got %0d", d.length_bytes, rsp.length_bytes);
          error_count++;
        end
        if (rsp.short_target !== d.short_target) begin
          $error("short_target: expected %h got %h", d.short_target, rsp.short_target);
          error_count++;
        end
        if (rsp.short_offset !== d.short_offset) begin
          $error("short_offset: expected %0d got %0d", d.short_offset, rsp.short_offset);
          error_count++;
        end
      end
    end
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (drain_stall > 0) begin
      drain_stall <= drain_stall - 1;
      rsp.ready <= 1'b0;
    end else if (fetch_queue.size() > QuietTail && $urandom_range(0, 5) == 0) begin
      drain_stall <= $urandom_range(1, 17) - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // End of run: wait for every decode to arrive, then print the verdict.
  initial begin
    wait (stimulus_done && decode_queue.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0 && decode_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end
endmodule
`default_nettype wire

@@ instruction_format_predecoder.f @@
+incdir+design
design/ifp_pkg.sv
design/ifp_if.sv
design/instruction_format_predecoder.sv
sim/testbench.sv
